### sv/crc16c_pkg.sv
// Package for the configurable CRC-16 block: widths, register indexes,
// reset values and the per-byte CRC update function.
// No dependencies.
package crc16c_pkg;

    localparam int CRC_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CRC_W-1:0] CRC_ONES      = 16'hFFFF;
    localparam logic [CRC_W-1:0] POLY_CCITT    = 16'h1021;
    localparam logic [CRC_W-1:0] POLY_FIRE     = 16'h782F;
    localparam logic [CRC_W-1:0] RST_POLY      = POLY_CCITT;
    localparam logic             RST_PRESET    = 1'b1;
    localparam logic             RST_INVERT    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY   = 2'd0,
        CFG_PRESET = 2'd1,
        CFG_INVERT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic             preset_ones;
        logic             invert_result;
    } t_cfg;

    // Fold one byte into the CRC, most significant bit first.
    function automatic logic [CRC_W-1:0] crc_feed_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/crc16c_if.sv
// Handshake interfaces of the CRC-16 block: byte input, CRC output and
// configuration write channel. Depends on crc16c_pkg.
interface crc16c_in_if;
    import crc16c_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16c_out_if;
    import crc16c_pkg::*;
    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] crc_value;
    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

interface crc16c_cfg_if;
    import crc16c_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/crc16c_cfg_regs.sv
// Configuration registers of the CRC-16 block.
// Depends on crc16c_pkg and crc16c_cfg_if.
module crc16c_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    crc16c_cfg_if.sink          i_cfg,
    output crc16c_pkg::t_cfg    o_cfg
);
    import crc16c_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_POLY:   n_cfg.poly          = i_cfg.data;
                CFG_PRESET: n_cfg.preset_ones   = i_cfg.data[0];
                CFG_INVERT: n_cfg.invert_result = i_cfg.data[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly          <= RST_POLY;
            r_cfg.preset_ones   <= RST_PRESET;
            r_cfg.invert_result <= RST_INVERT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### sv/crc16c_core.sv
// Input register, per-byte CRC update and running CRC of the CRC-16 block.
// Depends on crc16c_pkg and crc16c_in_if.
module crc16c_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  crc16c_pkg::t_cfg               i_cfg,
    crc16c_in_if.sink                      i_data,
    output logic                           o_res_valid,
    output logic [crc16c_pkg::CRC_W-1:0]   o_res_crc,
    input  logic                           i_res_ready
);
    import crc16c_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [CRC_W-1:0]  r_crc;
    logic              r_start;

    logic [CRC_W-1:0] n_crc;
    logic [CRC_W-1:0] base;
    logic             advance;
    logic             accept;

    assign base    = r_start ? (i_cfg.preset_ones ? CRC_ONES : '0) : r_crc;
    assign n_crc   = crc_feed_byte(base, r_byte, i_cfg.poly);
    assign advance = r_valid && (!r_last || i_res_ready);
    assign i_data.ready = !r_valid || advance;
    assign accept  = i_data.valid && i_data.ready;

    assign o_res_valid = r_valid && r_last;
    assign o_res_crc   = i_cfg.invert_result ? (n_crc ^ CRC_ONES) : n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_start <= 1'b1;
            r_crc   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            if (advance) begin
                r_crc   <= n_crc;
                r_start <= r_last;
            end
        end
        if (accept) begin
            r_byte <= i_data.data_byte;
            r_last <= i_data.last_byte;
        end
    end
endmodule

### sv/crc16c_out_reg.sv
// Output register of the CRC-16 block; holds one finished CRC until taken.
// Depends on crc16c_pkg and crc16c_out_if.
module crc16c_out_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [crc16c_pkg::CRC_W-1:0]   i_crc,
    output logic                           o_ready,
    crc16c_out_if.source                   o_crc
);
    import crc16c_pkg::*;

    logic             r_valid;
    logic [CRC_W-1:0] r_crc;

    assign o_ready = !r_valid || o_crc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_crc <= i_crc;
        end
    end

    assign o_crc.valid     = r_valid;
    assign o_crc.crc_value = r_crc;
endmodule

### sv/crc16_configurable_top.sv
// Configurable CRC-16, MSB first, not reflected, one message byte per item.
// A byte is taken every cycle unless the output is stalled; each byte passes an
// input register and the eight-step shift and XOR update, and the CRC of a
// message is loaded from there into the output register, later only while
// the output is stalled. Throughput is one item per cycle unless the output is
// stalled, set by the byte update loop on the running CRC register.
// Configuration writes take effect at the next clock edge and should be made
// while no message is in progress.
// Depends on crc16c_pkg, crc16c_if, crc16c_cfg_regs, crc16c_core, crc16c_out_reg.
module crc16_configurable_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crc16c_cfg_if.sink    i_cfg,
    crc16c_in_if.sink     i_data,
    crc16c_out_if.source  o_crc
);
    import crc16c_pkg::*;

    t_cfg             cfg;
    logic             res_valid;
    logic [CRC_W-1:0] res_crc;
    logic             res_ready;

    crc16c_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    crc16c_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_data      (i_data),
        .o_res_valid (res_valid),
        .o_res_crc   (res_crc),
        .i_res_ready (res_ready)
    );

    crc16c_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_crc   (res_crc),
        .o_ready (res_ready),
        .o_crc   (o_crc)
    );
endmodule

### sv/crc16c_checker.sv
// Port-level checks for the CRC-16 block, bound to its top level.
// Depends on crc16c_pkg and crc16_configurable_top.
module crc16c_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_last,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [crc16c_pkg::CRC_W-1:0]  i_crc_value,
    input logic                          i_cfg_ready
);
    import crc16c_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("CRC output dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_crc_value))
        else $error("CRC output changed while stalled");

    a_last_gives_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |-> ##2 i_out_valid)
        else $error("No CRC two cycles after a last byte");

    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled while the output is empty");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("Configuration channel not ready");
endmodule

bind crc16_configurable_top crc16c_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_data.valid),
    .i_in_ready  (i_data.ready),
    .i_in_last   (i_data.last_byte),
    .i_out_valid (o_crc.valid),
    .i_out_ready (o_crc.ready),
    .i_crc_value (o_crc.crc_value),
    .i_cfg_ready (i_cfg.ready)
);

### tb/crc16_configurable_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc16_configurable_top: drives message bytes, writes
// the configuration between messages and checks every CRC against a local predictor.
// Depends on crc16c_pkg, crc16c_if and the crc16_configurable_top RTL.
module crc16_configurable_top_test;
    import crc16c_pkg::*;

    class crc_scoreboard;
        logic [CRC_W-1:0] poly;
        bit               preset_ones;
        bit               invert_out;
        logic [CRC_W-1:0] running;
        bit               at_start;
        logic [CRC_W-1:0] expected_crcs[$];
        int               errors;

        function new();
            poly        = RST_POLY;
            preset_ones = RST_PRESET;
            invert_out  = RST_INVERT;
            running     = '0;
            at_start    = 1'b1;
            errors      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            unique case (idx)
                CFG_POLY: begin
                    poly = value;
                end
                CFG_PRESET: begin
                    preset_ones = value[0];
                end
                CFG_INVERT: begin
                    invert_out = value[0];
                end
                default: begin
                end
            endcase
        endfunction

        // Bit-serial LFSR form: feedback is the top CRC bit XOR the next data bit.
        function logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] c;
            logic             fb;
            c = crc;
            for (int k = BYTE_W - 1; k >= 0; k--) begin
                fb = c[CRC_W-1] ^ b[k];
                c  = {c[CRC_W-2:0], 1'b0};
                if (fb) begin
                    c = c ^ poly;
                end
            end
            return c;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            logic [CRC_W-1:0] base;
            base = at_start ? (preset_ones ? CRC_ONES : '0) : running;
            running = fold_byte(base, b);
            at_start = last;
            if (last) begin
                expected_crcs.push_back(invert_out ? running ^ CRC_ONES : running);
            end
        endfunction

        function int pending();
            return expected_crcs.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_crc(logic [CRC_W-1:0] got);
            logic [CRC_W-1:0] want;
            if (expected_crcs.size() == 0) begin
                report_mismatch($sformatf("crc_value %04h with no message pending", got));
            end else begin
                want = expected_crcs.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("crc_value %04h, predicted %04h", got, want));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    crc16c_cfg_if cfg_if ();
    crc16c_in_if  in_if ();
    crc16c_out_if out_if ();

    crc_scoreboard sb;

    crc16_configurable_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_data  (in_if),
        .o_crc   (out_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function bit idle_now();
        return !steady && ($urandom_range(0, 99) < 31);
    endfunction

    always @(posedge i_clk) begin
        out_if.ready <= !idle_now();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            sb.write_reg(t_cfg_idx'(cfg_if.index), cfg_if.data);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            sb.note_byte(in_if.data_byte, in_if.last_byte);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_crc(out_if.crc_value);
        end
    end

    task send_byte(logic [BYTE_W-1:0] b, logic last);
        while (idle_now()) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= last;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task send_random_message(int len);
        for (int i = 0; i < len; i++) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task set_config(logic [CRC_W-1:0] poly, bit pre, bit inv);
        write_reg(CFG_POLY, poly);
        write_reg(CFG_PRESET, CFG_DATA_W'(pre));
        write_reg(CFG_INVERT, CFG_DATA_W'(inv));
        cfg_if.valid <= 1'b0;
    endtask

    task run_phase(logic [CRC_W-1:0] poly, bit pre, bit inv, int nbytes, bit pause_mid);
        int  sent;
        int  len;
        bit  paused;
        wait_idle();
        set_config(poly, pre, inv);
        sent   = 0;
        paused = 1'b0;
        while (sent < nbytes) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            send_random_message(len);
            sent += len;
            if (pause_mid && !paused && sent >= nbytes / 2) begin
                wait_idle();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        #3_000_000;
        $display("crc16_configurable_top_test NOT OK");
        $finish;
    end

    initial begin
        sb = new();
        steady = 1'b0;
        i_rst_n <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_POLY;
        cfg_if.data <= '0;
        in_if.valid <= 1'b0;
        in_if.data_byte <= '0;
        in_if.last_byte <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: single-byte messages at the byte extremes,
        // the standard check string and a short mixed message.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        for (int i = 0; i < 9; i++) begin
            send_byte(8'h31 + BYTE_W'(i), i == 8);
        end
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        steady = 1'b1;
        run_phase(POLY_CCITT, 1'b1, 1'b1, 250, 1'b0);
        steady = 1'b0;
        run_phase(POLY_FIRE, 1'b0, 1'b0, 250, 1'b1);
        run_phase(16'h0000, 1'b0, 1'b1, 150, 1'b0);
        run_phase(16'hFFFF, 1'b1, 1'b0, 150, 1'b0);
        for (int p = 0; p < 3; p++) begin
            run_phase(CRC_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 230, 1'b0);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("crc16_configurable_top_test OK");
        end else begin
            $display("crc16_configurable_top_test NOT OK");
        end
        $finish;
    end

endmodule
